[design/gdr_pkg.sv]
// Shared types and constants of the grid DDA wall raycaster.
// Depends on nothing; gdr_div and the raycaster import it.
package gdr_pkg;

  localparam int MAP_SIZE_DEF      = 32;
  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 240;
  localparam int TEX_SIZE_DEF      = 64;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 21;
  localparam int DIV_W  = 32;

  localparam logic [31:0] DIST_MAX   = 32'hFFFF_FFFF;
  localparam logic [31:0] RECIP_NUM  = 32'h4000_0000;
  localparam logic [15:0] LH_MAX     = 16'hFFFF;
  localparam logic [21:0] TEXV_MAX   = 22'h3F_FFFF;

  localparam logic [20:0] POS_X_RST   = 21'd1441792;
  localparam logic [20:0] POS_Y_RST   = 21'd786432;
  localparam logic [15:0] DIR_X_RST   = 16'hC000;
  localparam logic [15:0] DIR_Y_RST   = 16'h0000;
  localparam logic [15:0] PLANE_X_RST = 16'h0000;
  localparam logic [15:0] PLANE_Y_RST = 16'd10813;

  typedef enum logic [CFG_IW-1:0] {
    CFG_POS_X, CFG_POS_Y, CFG_DIR_X, CFG_DIR_Y, CFG_PLANE_X, CFG_PLANE_Y
  } cfg_idx_t;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_CAST  = 1'b1
  } func_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CAM_MUL, ST_RAY_MUL, ST_RAY_ADD, ST_DX_DIV, ST_DY_DIV,
    ST_SIDE_MUL, ST_SIDE_SET, ST_STEP, ST_READ, ST_PERP, ST_LH_DIV,
    ST_SPAN, ST_TEX, ST_TSTEP_DIV, ST_TS_MUL, ST_OUT
  } gdr_state_t;

  typedef struct packed {
    logic       func;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [3:0] cell_value;
    logic [8:0] column;
  } in_req_t;

  typedef struct packed {
    logic [8:0]  out_column;
    logic [4:0]  hit_x;
    logic [4:0]  hit_y;
    logic [3:0]  wall_texture;
    logic        hit_side;
    logic [7:0]  span_start;
    logic [7:0]  span_end;
    logic [5:0]  tex_column;
    logic [21:0] tex_step;
    logic [21:0] tex_start;
    logic        no_hit;
  } out_rsp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[design/gdr_stream_if.sv]
// Valid/ready stream channel carrying one payload of type T.
// Depends on nothing; the payload types come from gdr_pkg.
interface gdr_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/gdr_div.sv]
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on gdr_pkg (status struct).
module gdr_div #(
  parameter int W = gdr_pkg::DIV_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [W-1:0]        num,
  input  logic [W-1:0]        den,
  output gdr_pkg::div_stat_t  stat,
  output logic [W-1:0]        quot
);
  import gdr_pkg::*;

  localparam int CW = $clog2(W);

  logic            busy_r, done_r;
  logic [CW-1:0]   cnt_r;
  logic [W:0]      rem_r;
  logic [W-1:0]    q_r, den_r;
  logic [W:0]      rem_sh;
  logic            ge;

  assign rem_sh = {rem_r[W-1:0], q_r[W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sh - {1'b0, den_r} : rem_sh;
      q_r   <= {q_r[W-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;
endmodule

[design/grid_dda_wall_raycaster.sv]
// Grid DDA wall raycaster. A write request stores one 4-bit wall type in the on-chip map
// (no result). A cast request forms the ray of one screen column and walks the map one
// cell per step until a nonzero cell, the map edge or 2*MAP_SIZE steps. It returns one
// result: hit cell, side, texture index, clipped span and texture values. A cast that
// finds no wall skips the line height and texture step divisions. Four divisions share
// the single radix-2 divider (both ray reciprocals, line height, texture step; a zero
// divisor skips its division). Each DDA step issues one map read and checks the
// registered read data in the following cycle.
// Camera x comes from one multiply by the reciprocal of the screen width.
// The map memory holds no reset; cells read before being written are undefined.
// A finished result waits in the output register while the next request is taken.
module grid_dda_wall_raycaster #(
  parameter int MAP_SIZE      = gdr_pkg::MAP_SIZE_DEF,
  parameter int SCREEN_WIDTH  = gdr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = gdr_pkg::SCREEN_HEIGHT_DEF,
  parameter int TEX_SIZE      = gdr_pkg::TEX_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gdr_stream_if.sink                  in_req,
  gdr_stream_if.source                out_rsp,
  input  logic                        cfg_we,
  input  logic [gdr_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [gdr_pkg::CFG_DW-1:0]  cfg_data
);
  import gdr_pkg::*;

  localparam int IW    = $clog2(MAP_SIZE);
  localparam int AW    = $clog2(MAP_SIZE * MAP_SIZE);
  localparam int DEPTH = MAP_SIZE * MAP_SIZE;
  localparam int MXW   = $clog2((MAP_SIZE > 32) ? MAP_SIZE : 32) + 2;
  localparam int SCW   = $clog2(2 * MAP_SIZE + 1);
  localparam int TXW   = $clog2(TEX_SIZE);
  localparam logic [31:0] LH_NUM = 32'(SCREEN_HEIGHT * 65536);
  localparam logic [31:0] TS_NUM = 32'(TEX_SIZE * 65536);
  // rounded-up 2^40 / SCREEN_WIDTH; exact quotient for every camera offset
  localparam longint CAM_M = ((longint'(1) << 40) + longint'(SCREEN_WIDTH) - 1)
                             / longint'(SCREEN_WIDTH);

  // configuration registers
  logic [20:0]        pos_x_r, pos_y_r;
  logic signed [15:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;

  // control
  gdr_state_t state_r, state_nxt;
  logic       div_wait_r;
  logic       div_start, div_skip;
  logic [31:0] div_num, div_den, div_q;
  div_stat_t  div_stat;

  // datapath
  logic [8:0]         col_r;
  logic signed [17:0] cam_r, rx_r, ry_r;
  logic signed [33:0] pmx_r, pmy_r;
  logic [31:0]        dx_r, dy_r, sdx_r, sdy_r, perp_r;
  logic [48:0]        psx_r, psy_r;
  logic signed [MXW-1:0] mx_r, my_r;
  logic               side_r, nh_r;
  logic [SCW-1:0]     step_cnt_r;
  logic [15:0]        lh_r;
  logic [12:0]        start_r, end_r;
  logic signed [50:0] wprod_r;
  logic [TXW-1:0]     tx_r;
  logic [21:0]        tstep_r;
  logic signed [41:0] tsprod_r;

  // map memory
  logic [3:0]    map_mem [DEPTH];
  logic [3:0]    map_rd_r;
  logic          map_we, map_re;
  logic [AW-1:0] map_wa, map_ra;

  // output register
  out_rsp_t out_data_r, out_nxt;
  logic     out_valid_r, out_load;

  // ---------------- configuration writes ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= POS_X_RST;
      pos_y_r   <= POS_Y_RST;
      dir_x_r   <= DIR_X_RST;
      dir_y_r   <= DIR_Y_RST;
      plane_x_r <= PLANE_X_RST;
      plane_y_r <= PLANE_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POS_X:   pos_x_r   <= cfg_data;
        CFG_POS_Y:   pos_y_r   <= cfg_data;
        CFG_DIR_X:   dir_x_r   <= cfg_data[15:0];
        CFG_DIR_Y:   dir_y_r   <= cfg_data[15:0];
        CFG_PLANE_X: plane_x_r <= cfg_data[15:0];
        CFG_PLANE_Y: plane_y_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- request intake ----------------
  logic       in_fire;
  logic [12:0] col_ext;
  logic [8:0]  col_clamp;

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign col_ext      = 13'(in_req.data.column);
  // clamp a column past the screen edge to the last column
  assign col_clamp    = (32'(col_ext) >= 32'(SCREEN_WIDTH)) ? 9'(SCREEN_WIDTH - 1)
                                                            : in_req.data.column;

  // writes land only in the idle state and reads only while walking, so the
  // two ports never touch the memory in the same cycle
  assign map_we = in_fire && (in_req.data.func == FUNC_WRITE)
                  && (32'(in_req.data.cell_x) < 32'(MAP_SIZE))
                  && (32'(in_req.data.cell_y) < 32'(MAP_SIZE));
  assign map_wa = AW'(in_req.data.cell_x) * AW'(MAP_SIZE) + AW'(in_req.data.cell_y);

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= in_req.data.cell_value;
    if (map_re) map_rd_r <= map_mem[map_ra];
  end

  // ---------------- camera x and ray ----------------
  logic signed [13:0] cam_d;
  logic [12:0]        cam_mag;
  logic [49:0]        cam_prod;
  logic signed [17:0] cam_q;
  logic [16:0]        rx_abs, ry_abs;
  logic signed [17:0] rx_full, ry_full;

  assign cam_d    = $signed({4'b0, col_r, 1'b0}) - $signed(14'(SCREEN_WIDTH));
  assign cam_mag  = cam_d[13] ? 13'(-cam_d) : 13'(cam_d);
  // |cam| * 2^16 / SCREEN_WIDTH, truncated, by reciprocal multiply
  assign cam_prod = 50'(cam_mag) * 50'(CAM_M);
  assign cam_q    = $signed({1'b0, cam_prod[40:24]});
  assign rx_full = rx_r[17] ? -rx_r : rx_r;
  assign ry_full = ry_r[17] ? -ry_r : ry_r;
  assign rx_abs  = rx_full[16:0];
  assign ry_abs  = ry_full[16:0];

  // ---------------- divider sharing ----------------
  always_comb begin
    div_num  = RECIP_NUM;
    div_den  = 32'd1;
    div_skip = 1'b0;
    unique case (state_r)
      ST_DX_DIV: begin
        div_den  = 32'(rx_abs);
        div_skip = (rx_r == '0);
      end
      ST_DY_DIV: begin
        div_den  = 32'(ry_abs);
        div_skip = (ry_r == '0);
      end
      ST_LH_DIV: begin
        div_num  = LH_NUM;
        div_den  = perp_r;
        div_skip = (perp_r == '0);
      end
      ST_TSTEP_DIV: begin
        div_num  = TS_NUM;
        div_den  = 32'(lh_r);
        div_skip = (lh_r == '0);
      end
      default: ;
    endcase
  end

  logic in_div, div_adv;
  assign in_div    = (state_r == ST_DX_DIV) || (state_r == ST_DY_DIV) ||
                     (state_r == ST_LH_DIV) || (state_r == ST_TSTEP_DIV);
  assign div_start = in_div && !div_wait_r && !div_skip;
  // leave a divide state when the operand is degenerate or the quotient is in
  assign div_adv   = (!div_wait_r && div_skip) || (div_wait_r && div_stat.done);

  gdr_div #(.W(DIV_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (div_q)
  );

  // ---------------- DDA step ----------------
  logic              take_x, oob;
  logic [32:0]       sdx_sum, sdy_sum;
  logic signed [MXW-1:0] mx_n, my_n, map_lim;

  assign take_x  = sdx_r < sdy_r;
  assign sdx_sum = {1'b0, sdx_r} + {1'b0, dx_r};
  assign sdy_sum = {1'b0, sdy_r} + {1'b0, dy_r};
  assign mx_n    = take_x  ? (rx_r[17] ? mx_r - 1'b1 : mx_r + 1'b1) : mx_r;
  assign my_n    = !take_x ? (ry_r[17] ? my_r - 1'b1 : my_r + 1'b1) : my_r;
  assign map_lim = MXW'(MAP_SIZE);
  // stepping off any edge of the map ends the walk without a wall
  assign oob     = (mx_n < 0) || (mx_n >= map_lim) || (my_n < 0) || (my_n >= map_lim);
  assign map_re  = (state_r == ST_STEP) && !oob;
  assign map_ra  = AW'(mx_n[IW-1:0]) * AW'(MAP_SIZE) + AW'(my_n[IW-1:0]);

  // ---------------- span and texture ----------------
  logic [16:0] lh_ext, half_dn, half_up;
  logic [15:0] frac;
  logic [31:0] tx_prod;
  logic [TXW-1:0] tx_raw;
  logic        mirror;
  logic signed [18:0] ts_base;
  logic [21:0] ts_clamp;

  assign lh_ext  = 17'(lh_r);
  assign half_dn = (17'(SCREEN_HEIGHT) - lh_ext) >> 1;
  assign half_up = (17'(SCREEN_HEIGHT) + lh_ext) >> 1;
  // keep only the fraction of the wall hit coordinate
  assign frac    = (side_r ? pos_x_r[15:0] : pos_y_r[15:0]) + wprod_r[29:14];
  assign tx_prod = 32'(frac) * 32'(TEX_SIZE);
  assign tx_raw  = TXW'(tx_prod >> 16);
  assign mirror  = (!side_r && !rx_r[17] && (rx_r != '0)) || (side_r && ry_r[17]);
  assign ts_base = $signed(19'(start_r)) - $signed(19'(SCREEN_HEIGHT / 2))
                   + $signed(19'(lh_r >> 1));
  assign ts_clamp = tsprod_r[41] ? 22'd0
                  : (tsprod_r > 42'sd4194303) ? TEXV_MAX : tsprod_r[21:0];

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_wait_r <= 1'b0;
      step_cnt_r <= '0;
      nh_r       <= 1'b0;
    end else begin
      if (div_start) div_wait_r <= 1'b1;
      else if (div_wait_r && div_stat.done) div_wait_r <= 1'b0;

      if (in_fire) nh_r <= 1'b0;
      unique case (state_r)
        ST_SIDE_SET: step_cnt_r <= '0;
        ST_STEP: begin
          step_cnt_r <= step_cnt_r + 1'b1;
          if (oob) nh_r <= 1'b1;
        end
        ST_READ:
          if (map_rd_r == '0 && step_cnt_r == SCW'(2 * MAP_SIZE)) nh_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) col_r <= col_clamp;
    unique case (state_r)
      ST_CAM_MUL: cam_r <= cam_d[13] ? -cam_q : cam_q;
      ST_RAY_MUL: begin
        pmx_r <= plane_x_r * cam_r;
        pmy_r <= plane_y_r * cam_r;
      end
      ST_RAY_ADD: begin
        // floor of plane*cam/2^16 is the arithmetic shift
        rx_r <= 18'(dir_x_r) + pmx_r[33:16];
        ry_r <= 18'(dir_y_r) + pmy_r[33:16];
      end
      ST_DX_DIV:
        if (!div_wait_r && div_skip) dx_r <= DIST_MAX;
        else if (div_wait_r && div_stat.done) dx_r <= div_q;
      ST_DY_DIV:
        if (!div_wait_r && div_skip) dy_r <= DIST_MAX;
        else if (div_wait_r && div_stat.done) dy_r <= div_q;
      ST_SIDE_MUL: begin
        psx_r <= (rx_r[17] ? 17'(pos_x_r[15:0]) : 17'h10000 - 17'(pos_x_r[15:0])) * dx_r;
        psy_r <= (ry_r[17] ? 17'(pos_y_r[15:0]) : 17'h10000 - 17'(pos_y_r[15:0])) * dy_r;
      end
      ST_SIDE_SET: begin
        sdx_r <= psx_r[47:16];
        sdy_r <= psy_r[47:16];
        mx_r  <= MXW'(pos_x_r[20:16]);
        my_r  <= MXW'(pos_y_r[20:16]);
      end
      ST_STEP: begin
        if (take_x) sdx_r <= sdx_sum[32] ? DIST_MAX : sdx_sum[31:0];
        else        sdy_r <= sdy_sum[32] ? DIST_MAX : sdy_sum[31:0];
        mx_r   <= mx_n;
        my_r   <= my_n;
        side_r <= !take_x;
      end
      ST_PERP: perp_r <= side_r ? sdy_r - dy_r : sdx_r - dx_r;
      ST_LH_DIV:
        if (!div_wait_r && div_skip) lh_r <= LH_MAX;
        else if (div_wait_r && div_stat.done)
          lh_r <= (div_q > 32'(LH_MAX)) ? LH_MAX : div_q[15:0];
      ST_SPAN: begin
        start_r <= (32'(lh_r) >= 32'(SCREEN_HEIGHT)) ? 13'd0 : half_dn[12:0];
        end_r   <= (32'(half_up) >= 32'(SCREEN_HEIGHT)) ? 13'(SCREEN_HEIGHT - 1)
                                                       : half_up[12:0];
        wprod_r <= $signed({1'b0, perp_r}) * (side_r ? rx_r : ry_r);
      end
      ST_TEX: tx_r <= mirror ? TXW'(TEX_SIZE - 1) - tx_raw : tx_raw;
      ST_TSTEP_DIV:
        if (!div_wait_r && div_skip) tstep_r <= TEXV_MAX;
        else if (div_wait_r && div_stat.done)
          tstep_r <= (div_q > 32'(TEXV_MAX)) ? TEXV_MAX : div_q[21:0];
      ST_TS_MUL: tsprod_r <= ts_base * $signed({1'b0, tstep_r});
      default: ;
    endcase
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE:
        if (in_fire && in_req.data.func == FUNC_CAST) state_nxt = ST_CAM_MUL;
      ST_CAM_MUL:   state_nxt = ST_RAY_MUL;
      ST_RAY_MUL:   state_nxt = ST_RAY_ADD;
      ST_RAY_ADD:   state_nxt = ST_DX_DIV;
      ST_DX_DIV:    if (div_adv) state_nxt = ST_DY_DIV;
      ST_DY_DIV:    if (div_adv) state_nxt = ST_SIDE_MUL;
      ST_SIDE_MUL:  state_nxt = ST_SIDE_SET;
      ST_SIDE_SET:  state_nxt = ST_STEP;
      ST_STEP:      state_nxt = oob ? ST_OUT : ST_READ;
      ST_READ: begin
        priority if (map_rd_r != '0) state_nxt = ST_PERP;
        else if (step_cnt_r == SCW'(2 * MAP_SIZE)) state_nxt = ST_OUT;
        else state_nxt = ST_STEP;
      end
      ST_PERP:      state_nxt = ST_LH_DIV;
      ST_LH_DIV:    if (div_adv) state_nxt = ST_SPAN;
      ST_SPAN:      state_nxt = ST_TEX;
      ST_TEX:       state_nxt = ST_TSTEP_DIV;
      ST_TSTEP_DIV: if (div_adv) state_nxt = ST_TS_MUL;
      ST_TS_MUL:    state_nxt = ST_OUT;
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_rsp.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_rsp.ready) out_valid_r <= 1'b0;
  end

  // a walk without a wall reports only its column and the no-hit flag
  always_comb begin
    out_nxt            = '0;
    out_nxt.out_column = col_r;
    out_nxt.no_hit     = nh_r;
    if (!nh_r) begin
      out_nxt.hit_x        = mx_r[4:0];
      out_nxt.hit_y        = my_r[4:0];
      out_nxt.wall_texture = map_rd_r - 4'd1;
      out_nxt.hit_side     = side_r;
      out_nxt.span_start   = start_r[7:0];
      out_nxt.span_end     = end_r[7:0];
      out_nxt.tex_column   = 6'(tx_r);
      out_nxt.tex_step     = tstep_r;
      out_nxt.tex_start    = ts_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= out_nxt;
  end

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

  // ---------------- checks ----------------
  a_step_limit: assert property (@(posedge clk) disable iff (!rst_n)
    step_cnt_r <= SCW'(2 * MAP_SIZE))
    else $error("walk ran past its step limit");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_map_ports: assert property (@(posedge clk) disable iff (!rst_n)
    map_re |-> !map_we)
    else $error("map read and write in the same cycle");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("loaded result not presented");
endmodule

[dv/gdr_checker.sv]
// Checker for the grid DDA wall raycaster: watches the request, result and register ports,
// predicts each cast result in fixed point and compares it with what the block returns.
// Depends on gdr_pkg for the request, result and register index types.
module gdr_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  gdr_pkg::in_req_t           in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  gdr_pkg::out_rsp_t          out_data,
  input  logic                       cfg_we,
  input  logic [gdr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [gdr_pkg::CFG_DW-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gdr_pkg::*;

  localparam longint DMAX = 64'hFFFF_FFFF;
  localparam longint TMAX = 64'h3F_FFFF;

  logic [3:0]  wall_cells [1024];
  logic [20:0] view_x, view_y;
  logic [15:0] look_x, look_y, cam_x, cam_y;
  out_rsp_t    column_q [$];

  function automatic longint inv_dist(input longint r);
    longint a;
    if (r == 0) return DMAX;
    a = (r < 0) ? -r : r;
    inv_dist = (64'd1 << 30) / a;
    if (inv_dist > DMAX) inv_dist = DMAX;
  endfunction

  function automatic longint clip_dist(input longint v);
    return (v > DMAX) ? DMAX : v;
  endfunction

  function automatic out_rsp_t cast_column(input logic [8:0] column);
    longint col, cam, rx, ry, dx, dy, sdx, sdy, fx, fy, mx, my, sxs, sys;
    longint perp, lh, start, stop, wall, frac, tx, tstep, ts;
    int side, steps;
    bit hit;
    logic [3:0] wtype;
    out_rsp_t r;
    r = '0;
    side = 0;
    hit = 0;
    wtype = '0;
    col = column;
    if (col >= 320) col = 319;
    cam = ((2 * col - 320) * 65536) / 320;
    rx = longint'($signed(look_x)) + ((longint'($signed(cam_x)) * cam) >>> 16);
    ry = longint'($signed(look_y)) + ((longint'($signed(cam_y)) * cam) >>> 16);
    dx = inv_dist(rx);
    dy = inv_dist(ry);
    mx = view_x >> 16;
    my = view_y >> 16;
    fx = view_x & 21'hFFFF;
    fy = view_y & 21'hFFFF;
    if (rx < 0) begin sxs = -1; sdx = clip_dist((fx * dx) >> 16); end
    else begin sxs = 1; sdx = clip_dist(((65536 - fx) * dx) >> 16); end
    if (ry < 0) begin sys = -1; sdy = clip_dist((fy * dy) >> 16); end
    else begin sys = 1; sdy = clip_dist(((65536 - fy) * dy) >> 16); end
    // Walk one cell per step; leave on a wall, the map edge or the step limit.
    for (steps = 0; steps < 64; steps++) begin
      if (sdx < sdy) begin
        sdx = clip_dist(sdx + dx); mx += sxs; side = 0;
      end else begin
        sdy = clip_dist(sdy + dy); my += sys; side = 1;
      end
      if (mx < 0 || mx >= 32 || my < 0 || my >= 32) break;
      wtype = wall_cells[mx * 32 + my];
      if (wtype != 0) begin
        hit = 1;
        break;
      end
    end
    r.out_column = col[8:0];
    if (!hit) begin
      r.no_hit = 1'b1;
      return r;
    end
    perp = side ? sdy - dy : sdx - dx;
    if (perp == 0) lh = 65535;
    else begin
      lh = (longint'(240) << 16) / perp;
      if (lh > 65535) lh = 65535;
    end
    start = (lh >= 240) ? 0 : (240 - lh) / 2;
    stop = (240 + lh) / 2;
    if (stop >= 240) stop = 239;
    if (side == 0) wall = longint'(view_y) + ((perp * ry) >>> 14);
    else wall = longint'(view_x) + ((perp * rx) >>> 14);
    frac = wall & 64'hFFFF;
    tx = (frac * 64) >> 16;
    // Mirror so the texture reads the same way from both faces.
    if ((side == 0 && rx > 0) || (side == 1 && ry < 0)) tx = 64 - tx - 1;
    if (lh == 0) tstep = TMAX;
    else begin
      tstep = (longint'(64) << 16) / lh;
      if (tstep > TMAX) tstep = TMAX;
    end
    ts = (start - 120 + lh / 2) * tstep;
    if (ts < 0) ts = 0;
    if (ts > TMAX) ts = TMAX;
    r.hit_x = mx[4:0];
    r.hit_y = my[4:0];
    r.wall_texture = wtype - 4'd1;
    r.hit_side = side[0];
    r.span_start = start[7:0];
    r.span_end = stop[7:0];
    r.tex_column = tx[5:0];
    r.tex_step = tstep[21:0];
    r.tex_start = ts[21:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_rsp_t exp_r;
    if (!rst_n) begin
      view_x <= POS_X_RST;
      view_y <= POS_Y_RST;
      look_x <= DIR_X_RST;
      look_y <= DIR_Y_RST;
      cam_x <= PLANE_X_RST;
      cam_y <= PLANE_Y_RST;
      for (int i = 0; i < 1024; i++) wall_cells[i] = '0;
      column_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_POS_X:   view_x <= cfg_data;
          CFG_POS_Y:   view_y <= cfg_data;
          CFG_DIR_X:   look_x <= cfg_data[15:0];
          CFG_DIR_Y:   look_y <= cfg_data[15:0];
          CFG_PLANE_X: cam_x <= cfg_data[15:0];
          CFG_PLANE_Y: cam_y <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (func_t'(in_data.func) == FUNC_WRITE)
          wall_cells[in_data.cell_x * 32 + in_data.cell_y] = in_data.cell_value;
        else
          column_q.push_back(cast_column(in_data.column));
      end
      if (out_valid && out_ready) begin
        if (column_q.size() == 0) begin
          $error("result for column %0d with no cast outstanding", out_data.out_column);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = column_q.pop_front();
          if (exp_r != out_data) begin
            fail_count <= fail_count + 1;
            if (exp_r.out_column != out_data.out_column)
              $error("out_column exp %0d got %0d", exp_r.out_column, out_data.out_column);
            if (exp_r.hit_x != out_data.hit_x)
              $error("hit_x exp %0d got %0d", exp_r.hit_x, out_data.hit_x);
            if (exp_r.hit_y != out_data.hit_y)
              $error("hit_y exp %0d got %0d", exp_r.hit_y, out_data.hit_y);
            if (exp_r.wall_texture != out_data.wall_texture)
              $error("wall_texture exp %0d got %0d", exp_r.wall_texture,
                     out_data.wall_texture);
            if (exp_r.hit_side != out_data.hit_side)
              $error("hit_side exp %0d got %0d", exp_r.hit_side, out_data.hit_side);
            if (exp_r.span_start != out_data.span_start)
              $error("span_start exp %0d got %0d", exp_r.span_start, out_data.span_start);
            if (exp_r.span_end != out_data.span_end)
              $error("span_end exp %0d got %0d", exp_r.span_end, out_data.span_end);
            if (exp_r.tex_column != out_data.tex_column)
              $error("tex_column exp %0d got %0d", exp_r.tex_column, out_data.tex_column);
            if (exp_r.tex_step != out_data.tex_step)
              $error("tex_step exp %0d got %0d", exp_r.tex_step, out_data.tex_step);
            if (exp_r.tex_start != out_data.tex_start)
              $error("tex_start exp %0d got %0d", exp_r.tex_start, out_data.tex_start);
            if (exp_r.no_hit != out_data.no_hit)
              $error("no_hit exp %0d got %0d", exp_r.no_hit, out_data.no_hit);
          end
        end
      end
    end
    pending <= column_q.size();
  end

endmodule

[dv/tb_grid_dda_wall_raycaster.sv]
// Top of the raycaster testbench: clock, reset, map loading, register phases and casts.
// Depends on gdr_pkg, gdr_stream_if, the block itself and gdr_checker.
module tb_grid_dda_wall_raycaster;
  timeunit 1ns;
  timeprecision 1ps;
  import gdr_pkg::*;

  localparam int QUIET_LIMIT = 40000;  // cycles with no request or result moving
  localparam int HOLD_CYCLES = 3000;   // long receiver hold-off

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_data = '0;
  int                  fail_count;
  int                  pending;
  int                  send_idle_pct = 16;
  int                  recv_idle_pct = 56;
  bit                  hold_req = 1'b0;
  int                  quiet_cycles = 0;

  gdr_stream_if #(.T(in_req_t))  in_req ();
  gdr_stream_if #(.T(out_rsp_t)) out_rsp ();

  always #1 clk = ~clk;

  grid_dda_wall_raycaster u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req.sink),
    .out_rsp   (out_rsp.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gdr_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_ready   (in_req.ready),
    .in_data    (in_req.data),
    .out_valid  (out_rsp.valid),
    .out_ready  (out_rsp.ready),
    .out_data   (out_rsp.data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    in_req.valid = 1'b0;
    in_req.data = '0;
    out_rsp.ready = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off so the block backs up and
  // stalls its request input while the sender keeps offering.
  always @(negedge clk) begin
    static int hold_left = 0;
    static bit hold_done = 1'b0;
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_rsp.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one request; called and returning at a falling edge, valid left high so a
  // following request goes out back to back.
  task automatic send_req(input in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.data <= r;
    do @(posedge clk); while (!in_req.ready);
    @(negedge clk);
  endtask

  task automatic put_cell(input int x, input int y, input int v);
    in_req_t r;
    r = '0;
    r.func = FUNC_WRITE;
    r.cell_x = x[4:0];
    r.cell_y = y[4:0];
    r.cell_value = v[3:0];
    r.column = 9'($urandom);
    send_req(r);
  endtask

  task automatic cast(input int c);
    in_req_t r;
    r = in_req_t'($urandom);
    r.func = FUNC_CAST;
    r.column = c[8:0];
    send_req(r);
  endtask

  // Drain all casts, then let a trailing write settle before touching registers.
  task automatic quiesce();
    in_req.valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Pick an extreme or a random value for a signed Q2.14 register.
  function automatic logic [15:0] pick_vec(input int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [20:0] pick_pos(input int mode);
    logic [20:0] p;
    p = 21'($urandom);
    case (mode)
      0: return 21'h0;
      1: return 21'h1F_FFFF;
      2: return {p[20:16], 16'h0};  // exactly on a cell boundary
      default: return p;
    endcase
  endfunction

  initial begin
    int v;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Load every cell once: solid border, sparse interior.
    for (int x = 0; x < 32; x++)
      for (int y = 0; y < 32; y++) begin
        if (x == 0 || y == 0 || x == 31 || y == 31) v = $urandom_range(15, 1);
        else v = ($urandom_range(99) < 12) ? $urandom_range(15, 1) : 0;
        put_cell(x, y, v);
      end

    // Directed: reset view, screen edges, center ray with a zero component,
    // out-of-range columns, extreme wall types.
    put_cell(21, 12, 15);
    cast(160);
    cast(0);
    cast(319);
    cast(320);
    cast(511);
    put_cell(21, 12, 1);
    cast(160);
    // Open the row to the border and a border cell so the ray walks off the map.
    put_cell(21, 12, 0);
    put_cell(0, 12, 0);
    for (int x = 1; x < 21; x++) put_cell(x, 12, 0);
    cast(160);
    quiesce();

    // Zero-distance hit: viewer on a boundary facing the wall next to it.
    set_reg(CFG_POS_X, 21'd1441792);
    set_reg(CFG_DIR_X, 16'hC000);
    set_reg(CFG_PLANE_Y, 16'h0000);
    put_cell(21, 12, 7);
    cast(160);
    cast(5);
    quiesce();

    // Random phases over several register settings.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin send_idle_pct = 56; recv_idle_pct = 16; end
      if (ph == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
      set_reg(CFG_POS_X, pick_pos(ph < 2 ? ph : $urandom_range(3)));
      set_reg(CFG_POS_Y, pick_pos(ph < 2 ? ph : $urandom_range(3)));
      set_reg(CFG_DIR_X, pick_vec(ph < 3 ? ph : $urandom_range(4)));
      set_reg(CFG_DIR_Y, pick_vec(ph < 3 ? 2 - ph : $urandom_range(4)));
      set_reg(CFG_PLANE_X, pick_vec(ph < 3 ? ph : $urandom_range(4)));
      set_reg(CFG_PLANE_Y, pick_vec(ph < 3 ? (ph + 1) % 3 : $urandom_range(4)));
      for (int i = 0; i < 70; i++) begin
        if (ph == 1 && i == 50) hold_req = 1'b1;
        if ($urandom_range(99) < 65) begin
          cast($urandom_range(511));
        end else begin
          // Phase four mostly clears cells so long walks and step limits appear.
          v = ($urandom_range(99) < (ph == 4 ? 95 : 60)) ? 0 : $urandom_range(15, 1);
          put_cell($urandom_range(31), $urandom_range(31), v);
        end
      end
      quiesce();
    end

    repeat (400) @(negedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
